// ----- src/csm_pkg.sv -----
package csm_pkg;

    // field widths
    localparam int ACTION_W   = 2;
    localparam int SAMPLE_W   = 24;
    localparam int VSTEP_W    = 16;
    localparam int CAP_W      = 16;
    localparam int CURRENT_W  = 25;
    localparam int SPIKE_W    = 32;
    localparam int PEAK_W     = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ADD     = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_EXTRACT = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_CURRENT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_SPIKE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_US     = 2'd2;

    // register reset values
    localparam logic [CFG_DATA_W-1:0] ALPHA_RESET  = 16'd4096;
    localparam logic [CFG_DATA_W-1:0] PERIOD_RESET = 16'd1000;

endpackage

// ----- src/csm_if.sv -----
interface csm_in_if;
    import csm_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic                       sample_valid;
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [VSTEP_W-1:0]  volt_step;
    logic [CAP_W-1:0]           capacitance;

    modport source (output valid, action, sample_valid, sample, volt_step, capacitance,
                    input ready);
    modport sink   (input valid, action, sample_valid, sample, volt_step, capacitance,
                    output ready);
endinterface

interface csm_out_if;
    import csm_pkg::*;
    logic                        valid;
    logic                        ready;
    logic signed [CURRENT_W-1:0] present_current;
    logic signed [CURRENT_W-1:0] smoothed_current;
    logic [SPIKE_W-1:0]          predicted_spike;
    logic [PEAK_W-1:0]           peak_reading;

    modport source (output valid, present_current, smoothed_current, predicted_spike,
                    peak_reading, input ready);
    modport sink   (input valid, present_current, smoothed_current, predicted_spike,
                    peak_reading, output ready);
endinterface

interface csm_cfg_if;
    import csm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/current_spike_monitor_unit.sv -----
// Path from accepted input word to valid result word: tick runs the current, then the
//   spike filter pass and the max scan; add spike multiplies, divides, saturates and scans;
// extract only scans. Built on the shared 33x17 multiplier (two filter passes), the 32-step
// restoring divider and the one-slot-a-cycle max scan; a new word waits for the result.
// Reset (synchronous, active low) returns config registers, history, filters and peak to
// their reset values; no clearing pass.
module current_spike_monitor_unit #(
    parameter int HISTORY_LEN = 10
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    csm_in_if.sink    i_in,
    csm_out_if.source o_out,
    csm_cfg_if.sink   i_cfg
);
    import csm_pkg::*;

    localparam int LAST = HISTORY_LEN - 1;
    localparam int TAP  = HISTORY_LEN - 2;
    localparam int CW   = $clog2(HISTORY_LEN);

    localparam logic [1:0] SEL_CUR = 2'd0;
    localparam logic [1:0] SEL_SPK = 2'd1;
    localparam logic [1:0] SEL_ADD = 2'd2;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_ACC  = 7'b0000100,
        S_DIV  = 7'b0001000,
        S_SAT  = 7'b0010000,
        S_SCAN = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state                      r_state;
    logic [1:0]                  r_sel;
    logic [15:0]                 r_alpha_c;
    logic [15:0]                 r_alpha_s;
    logic [15:0]                 r_period;
    logic [SPIKE_W-1:0]          r_hist [HISTORY_LEN];
    logic signed [CURRENT_W-1:0] r_smoothed_value;
    logic [SPIKE_W-1:0]          r_smoothed_spike;
    logic [PEAK_W-1:0]           r_peak;
    logic signed [CURRENT_W-1:0] r_last_current;
    logic [PEAK_W-1:0]           r_peak_out;
    logic                        r_out_valid;
    logic [4:0]                  r_dcnt;
    logic [CW-1:0]               r_scnt;

    logic signed [49:0]          r_prod;
    logic [31:0]                 r_quo;
    logic [15:0]                 r_rem;
    logic [CAP_W-1:0]            r_cap;
    logic [15:0]                 r_vmag;
    logic [SPIKE_W-1:0]          r_max;

    logic signed [CURRENT_W-1:0] w_sample_ext;
    logic signed [CURRENT_W-1:0] w_cur;
    logic [CURRENT_W-1:0]        w_abs;
    logic [15:0]                 w_vmag;
    logic signed [25:0]          w_diff_c;
    logic signed [32:0]          w_diff_s;
    logic signed [32:0]          w_mul_a;
    logic signed [16:0]          w_mul_b;
    logic signed [49:0]          w_prod;
    logic signed [49:0]          w_rnd;
    logic signed [49:0]          w_step;
    logic signed [CURRENT_W-1:0] w_new_c;
    logic [SPIKE_W-1:0]          w_new_s;
    logic [15:0]                 w_dvs;
    logic [16:0]                 w_rem_sh;
    logic                        w_ge;
    logic [15:0]                 n_rem;
    logic [31:0]                 n_quo;
    logic [32:0]                 n_sum;

    assign w_sample_ext = CURRENT_W'(i_in.sample);
    assign w_cur        = i_in.sample_valid ? -w_sample_ext : '0;
    assign w_abs        = w_cur[CURRENT_W-1] ? CURRENT_W'(-w_cur) : CURRENT_W'(w_cur);
    assign w_vmag       = i_in.volt_step[15] ? 16'(~i_in.volt_step + 16'd1)
                                             : 16'(i_in.volt_step);

    assign w_diff_c = $signed({r_last_current[CURRENT_W-1], r_last_current})
                    - $signed({r_smoothed_value[CURRENT_W-1], r_smoothed_value});
    assign w_diff_s = $signed({1'b0, r_hist[TAP]}) - $signed({1'b0, r_smoothed_spike});

    // shared multiplier operand select
    always_comb begin
        case (r_sel)
            SEL_CUR: begin
                w_mul_a = 33'(w_diff_c);
                w_mul_b = $signed({1'b0, r_alpha_c});
            end
            SEL_SPK: begin
                w_mul_a = w_diff_s;
                w_mul_b = $signed({1'b0, r_alpha_s});
            end
            SEL_ADD: begin
                w_mul_a = $signed({17'b0, r_cap});
                w_mul_b = $signed({1'b0, r_vmag});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // round half up, then floor shift
    assign w_rnd   = r_prod + 50'sd32768;
    assign w_step  = w_rnd >>> 16;
    assign w_new_c = r_smoothed_value + $signed(w_step[CURRENT_W-1:0]);
    assign w_new_s = r_smoothed_spike + w_step[SPIKE_W-1:0];

    // restoring divider, one quotient bit a cycle
    assign w_dvs    = (r_period == 16'd0) ? 16'd1 : r_period;
    assign w_rem_sh = {r_rem, r_quo[31]};
    assign w_ge     = w_rem_sh >= {1'b0, w_dvs};
    assign n_rem    = w_ge ? 16'(w_rem_sh - {1'b0, w_dvs}) : w_rem_sh[15:0];
    assign n_quo    = {r_quo[30:0], w_ge};
    assign n_sum    = {1'b0, r_hist[LAST]} + {1'b0, r_quo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_sel            <= SEL_CUR;
            r_alpha_c        <= ALPHA_RESET;
            r_alpha_s        <= ALPHA_RESET;
            r_period         <= PERIOD_RESET;
            r_smoothed_value <= '0;
            r_smoothed_spike <= '0;
            r_peak           <= '0;
            r_last_current   <= '0;
            r_peak_out       <= '0;
            r_out_valid      <= 1'b0;
            r_dcnt           <= '0;
            r_scnt           <= '0;
            for (int i = 0; i < HISTORY_LEN; i++) begin
                r_hist[i] <= '0;
            end
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_ALPHA_CURRENT: r_alpha_c <= i_cfg.data;
                    CFG_ALPHA_SPIKE:   r_alpha_s <= i_cfg.data;
                    CFG_PERIOD_US:     r_period  <= i_cfg.data;
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_scnt <= '0;
                        case (i_in.action)
                            ACT_TICK: begin
                                r_peak_out     <= '0;
                                r_last_current <= w_cur;
                                if (w_abs[PEAK_W-1:0] > r_peak) begin
                                    r_peak <= w_abs[PEAK_W-1:0];
                                end
                                r_sel   <= SEL_CUR;
                                r_state <= S_MUL;
                            end
                            ACT_ADD: begin
                                r_peak_out <= '0;
                                r_sel      <= SEL_ADD;
                                r_state    <= S_MUL;
                            end
                            ACT_EXTRACT: begin
                                r_peak_out <= r_peak;
                                r_peak     <= '0;
                                r_state    <= S_SCAN;
                            end
                            default: begin
                                r_peak_out <= '0;
                                r_state    <= S_SCAN;
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    case (r_sel)
                        SEL_CUR: begin
                            r_smoothed_value <= w_new_c;
                            r_sel            <= SEL_SPK;
                            r_state          <= S_MUL;
                        end
                        SEL_SPK: begin
                            r_smoothed_spike <= w_new_s;
                            for (int i = 0; i < LAST; i++) begin
                                r_hist[i] <= r_hist[i+1];
                            end
                            r_hist[LAST] <= '0;
                            r_state      <= S_SCAN;
                        end
                        default: begin
                            r_dcnt  <= '0;
                            r_state <= S_DIV;
                        end
                    endcase
                end
                S_DIV: begin
                    r_dcnt <= r_dcnt + 5'd1;
                    if (r_dcnt == 5'd31) begin
                        r_state <= S_SAT;
                    end
                end
                S_SAT: begin
                    r_hist[LAST] <= n_sum[32] ? '1 : n_sum[31:0];
                    r_state      <= S_SCAN;
                end
                S_SCAN: begin
                    // rotate slots 0..TAP past the tap at slot 0
                    for (int i = 0; i < TAP; i++) begin
                        r_hist[i] <= r_hist[i+1];
                    end
                    r_hist[TAP] <= r_hist[0];
                    r_scnt      <= r_scnt + CW'(1);
                    if (r_scnt == CW'(TAP)) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (o_out.ready) begin
                        r_out_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers, no reset
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in.valid) begin
            r_cap  <= i_in.capacitance;
            r_vmag <= w_vmag;
            r_max  <= r_smoothed_spike;
        end
        if (r_state == S_MUL) begin
            r_prod <= w_prod;
        end
        if (r_state == S_ACC) begin
            r_quo <= r_prod[31:0];
            r_rem <= '0;
            r_max <= w_new_s;
        end
        if (r_state == S_DIV) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
        if (r_state == S_SAT) begin
            r_max <= r_smoothed_spike;
        end
        if (r_state == S_SCAN && r_hist[0] > r_max) begin
            r_max <= r_hist[0];
        end
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid            = r_out_valid;
    assign o_out.present_current  = r_last_current;
    assign o_out.smoothed_current = r_smoothed_value;
    assign o_out.predicted_spike  = r_max;
    assign o_out.peak_reading     = r_peak_out;

`ifndef SYNTHESIS
    a_ready_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !o_out.valid)
        else $error("input ready while a result word is pending");

    a_out_state_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> o_out.valid)
        else $error("result state without valid");

    a_sat_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SAT) |-> $past(r_state == S_DIV && r_dcnt == 5'd31))
        else $error("saturating add without a finished divide");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_scnt <= CW'(TAP)))
        else $error("max scan ran past the last history slot");
`endif

endmodule
